[rtl/core/ftfm_pkg.sv]
// shared types and constants for the five-tuple first-match classifier
package ftfm_pkg;

  localparam int unsigned IndexW  = 6;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned ProtoW  = 8;
  localparam int unsigned ActionW = 8;
  localparam int unsigned AddrSlots = 2 ** IndexW;

  typedef enum logic [1:0] {
    MODE_CLASSIFY = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  // word travelling along the cell chain, with its running result
  typedef struct packed {
    logic [1:0]         mode;
    logic [IndexW-1:0]  rule_index;
    logic [AddrW-1:0]   src_addr;
    logic [AddrW-1:0]   src_mask;
    logic [AddrW-1:0]   dst_addr;
    logic [AddrW-1:0]   dst_mask;
    logic [PortW-1:0]   src_port;
    logic [PortW-1:0]   src_port_high;
    logic [PortW-1:0]   dst_port;
    logic [PortW-1:0]   dst_port_high;
    logic [ProtoW-1:0]  protocol;
    logic [ActionW-1:0] action;
    logic               hit;
    logic [IndexW-1:0]  matched_index;
    logic [ActionW-1:0] matched_action;
  } word_t;

endpackage

[rtl/core/five_tuple_first_match_classifier.sv]
// top level of the five-tuple first-match classifier: cell chain and output register
// Each item (classify, write rule or clear slot) walks a chain of RULE_SLOTS
// cells, one cell per cycle while the chain is not held by back-pressure, and
// gives one result word; items are taken one at a time, so a new item is not
// accepted before the previous one has left the cell chain. The next item is
// accepted as soon as the chain is empty, even while the previous result still
// waits in the output register. Cell s holds rule slot s; lower slots see the
// packet first, so the first hit along the chain is the lowest matching slot.
// Writes and clears take effect when the item passes the addressed cell.
module five_tuple_first_match_classifier import ftfm_pkg::*; #(
  parameter int unsigned RULE_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [IndexW-1:0]  rule_index_i,
  input  logic [AddrW-1:0]   src_addr_i,
  input  logic [AddrW-1:0]   src_mask_i,
  input  logic [AddrW-1:0]   dst_addr_i,
  input  logic [AddrW-1:0]   dst_mask_i,
  input  logic [PortW-1:0]   src_port_i,
  input  logic [PortW-1:0]   src_port_high_i,
  input  logic [PortW-1:0]   dst_port_i,
  input  logic [PortW-1:0]   dst_port_high_i,
  input  logic [ProtoW-1:0]  protocol_i,
  input  logic [ActionW-1:0] action_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [IndexW-1:0]  matched_index_o,
  output logic [ActionW-1:0] matched_action_o
);

  // stage 0 is the input side, stage RULE_SLOTS the chain output
  logic  valid_s [RULE_SLOTS+1];
  word_t word_s  [RULE_SLOTS+1];
  logic  [RULE_SLOTS-1:0] busy;
  logic  en;
  logic  out_valid_q;
  logic  hit_q;
  logic  [IndexW-1:0]  idx_q;
  logic  [ActionW-1:0] act_q;

  // chain empty means no item in flight
  assign in_ready_o = ~|busy;

  always_comb begin
    word_s[0]                = '0;
    word_s[0].mode           = mode_i;
    word_s[0].rule_index     = rule_index_i;
    word_s[0].src_addr       = src_addr_i;
    word_s[0].src_mask       = src_mask_i;
    word_s[0].dst_addr       = dst_addr_i;
    word_s[0].dst_mask       = dst_mask_i;
    word_s[0].src_port       = src_port_i;
    word_s[0].src_port_high  = src_port_high_i;
    word_s[0].dst_port       = dst_port_i;
    word_s[0].dst_port_high  = dst_port_high_i;
    word_s[0].protocol       = protocol_i;
    word_s[0].action         = action_i;
  end
  assign valid_s[0] = in_valid_i && in_ready_o;

  // hold the chain while a finished word cannot leave
  assign en = !(valid_s[RULE_SLOTS] && out_valid_q && !out_ready_i);

  for (genvar s = 0; s < RULE_SLOTS; s++) begin : g_cell
    ftfm_cell #(.Slot(s)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[s]),
      .word_i  (word_s[s]),
      .valid_o (valid_s[s+1]),
      .word_o  (word_s[s+1])
    );
    assign busy[s] = valid_s[s+1];
  end

  // output register parts the chain from the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (valid_s[RULE_SLOTS] && en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_s[RULE_SLOTS] && en) begin
      hit_q <= word_s[RULE_SLOTS].hit;
      idx_q <= word_s[RULE_SLOTS].matched_index;
      act_q <= word_s[RULE_SLOTS].matched_action;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign matched_index_o  = idx_q;
  assign matched_action_o = act_q;

endmodule

[rtl/core/ftfm_cell.sv]
// one rule slot of the chain: holds a rule and registers the passing word
module ftfm_cell import ftfm_pkg::*; #(
  parameter int unsigned Slot = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  word_t word_i,
  output logic  valid_o,
  output word_t word_o
);

  localparam bit                Addressable = (Slot < AddrSlots);
  localparam logic [IndexW-1:0] SlotId      = IndexW'(Slot % AddrSlots);

  logic               rule_valid_q;
  logic [AddrW-1:0]   sa_q, sm_q, da_q, dm_q;
  logic [PortW-1:0]   spl_q, sph_q, dpl_q, dph_q;
  logic [ProtoW-1:0]  pr_q;
  logic [ActionW-1:0] act_q;
  logic               valid_q;
  word_t              word_q, word_d;
  logic               sel, match;

  assign sel = Addressable && (word_i.rule_index == SlotId);

  assign match = rule_valid_q
              && ((word_i.src_addr & sm_q) == (sa_q & sm_q))
              && ((word_i.dst_addr & dm_q) == (da_q & dm_q))
              && (word_i.src_port >= spl_q) && (word_i.src_port <= sph_q)
              && (word_i.dst_port >= dpl_q) && (word_i.dst_port <= dph_q)
              && ((pr_q == '0) || (pr_q == word_i.protocol));

  always_comb begin
    word_d = word_i;
    if ((word_i.mode == MODE_CLASSIFY) && !word_i.hit && match) begin
      word_d.hit            = 1'b1;
      word_d.matched_index  = SlotId;
      word_d.matched_action = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i && sel && (word_i.mode == MODE_WRITE)) begin
        rule_valid_q <= 1'b1;
      end else if (valid_i && sel && (word_i.mode == MODE_CLEAR)) begin
        rule_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
      if (valid_i && sel && (word_i.mode == MODE_WRITE)) begin
        sa_q  <= word_i.src_addr;
        sm_q  <= word_i.src_mask;
        da_q  <= word_i.dst_addr;
        dm_q  <= word_i.dst_mask;
        spl_q <= word_i.src_port;
        sph_q <= word_i.src_port_high;
        dpl_q <= word_i.dst_port;
        dph_q <= word_i.dst_port_high;
        pr_q  <= word_i.protocol;
        act_q <= word_i.action;
      end
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[tb/tb_five_tuple_first_match_classifier.sv]
// testbench for the five-tuple first-match classifier: directed and random traffic against a predictor
`timescale 1ns / 100ps

module tb_five_tuple_first_match_classifier;
  import ftfm_pkg::*;

  localparam int unsigned Slots = 64;
  localparam int unsigned NumRandom = 700;

  // one rule as held in the table
  typedef struct {
    bit              valid;
    bit [AddrW-1:0]  src_addr, src_mask, dst_addr, dst_mask;
    bit [PortW-1:0]  src_lo, src_hi, dst_lo, dst_hi;
    bit [ProtoW-1:0] proto;
    bit [ActionW-1:0] action;
  } rule_t;

  // one input word
  typedef struct {
    bit [1:0]          mode;
    bit [IndexW-1:0]   idx;
    bit [AddrW-1:0]    sa, sm, da, dm;
    bit [PortW-1:0]    sp, sph, dp, dph;
    bit [ProtoW-1:0]   pr;
    bit [ActionW-1:0]  act;
  } item_t;

  // one result word
  typedef struct {
    bit               hit;
    bit [IndexW-1:0]  index;
    bit [ActionW-1:0] action;
  } verdict_t;

  // scoreboard: holds a copy of the rule table and the verdicts still due
  class match_board;
    rule_t    table_q[Slots];
    verdict_t due_q[$];
    int       errors;

    function void note_item(item_t it);
      verdict_t v;
      v = '{default: 0};
      if (it.mode == MODE_CLASSIFY) begin
        for (int s = 0; s < Slots; s++) begin
          if (table_q[s].valid &&
              ((it.sa & table_q[s].src_mask) == (table_q[s].src_addr & table_q[s].src_mask)) &&
              ((it.da & table_q[s].dst_mask) == (table_q[s].dst_addr & table_q[s].dst_mask)) &&
              it.sp >= table_q[s].src_lo && it.sp <= table_q[s].src_hi &&
              it.dp >= table_q[s].dst_lo && it.dp <= table_q[s].dst_hi &&
              (table_q[s].proto == 0 || table_q[s].proto == it.pr)) begin
            v.hit = 1;
            v.index = IndexW'(s);
            v.action = table_q[s].action;
            break;
          end
        end
      end else if (it.mode == MODE_WRITE) begin
        table_q[it.idx] = '{1'b1, it.sa, it.sm, it.da, it.dm, it.sp, it.sph, it.dp, it.dph,
                            it.pr, it.act};
      end else if (it.mode == MODE_CLEAR) begin
        table_q[it.idx].valid = 0;
      end
      due_q.push_back(v);
    endfunction

    function void check_result(bit hit, bit [IndexW-1:0] index, bit [ActionW-1:0] action);
      verdict_t v;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0d index=%0d action=%0d", $time, hit, index,
                 action);
        errors++;
        return;
      end
      v = due_q.pop_front();
      if (hit !== v.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, v.hit, hit);
        errors++;
      end
      if (index !== v.index) begin
        $display("%0t: index expected %0d actual %0d", $time, v.index, index);
        errors++;
      end
      if (action !== v.action) begin
        $display("%0t: action expected %0d actual %0d", $time, v.action, action);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic [1:0]         mode_i = '0;
  logic [IndexW-1:0]  rule_index_i = '0;
  logic [AddrW-1:0]   src_addr_i = '0, src_mask_i = '0, dst_addr_i = '0, dst_mask_i = '0;
  logic [PortW-1:0]   src_port_i = '0, src_port_high_i = '0, dst_port_i = '0;
  logic [PortW-1:0]   dst_port_high_i = '0;
  logic [ProtoW-1:0]  protocol_i = '0;
  logic [ActionW-1:0] action_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic               hit_o;
  logic [IndexW-1:0]  matched_index_o;
  logic [ActionW-1:0] matched_action_o;

  match_board board = new();
  int  send_idle_pct = 0;   // chance of the sender resting in a cycle
  int  recv_stall_pct = 0;  // chance of the receiver stalling in a cycle
  bit  hold_off = 0;        // receiver held off for the long back-pressure stretch

  always #2 clk_i = ~clk_i;

  five_tuple_first_match_classifier #(.RULE_SLOTS(Slots)) DUT (.*);

  // receiver: random stalls, results checked at the edge where they are taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(hit_o, matched_index_o, matched_action_o);
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one word, hold it until taken, then maybe rest
  task automatic send_word(item_t it);
    in_valid_i <= 1;
    mode_i <= it.mode;
    rule_index_i <= it.idx;
    src_addr_i <= it.sa;
    src_mask_i <= it.sm;
    dst_addr_i <= it.da;
    dst_mask_i <= it.dm;
    src_port_i <= it.sp;
    src_port_high_i <= it.sph;
    dst_port_i <= it.dp;
    dst_port_high_i <= it.dph;
    protocol_i <= it.pr;
    action_i <= it.act;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
  endtask

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    bit [PortW-1:0] a, b;
    it.idx = IndexW'($urandom);
    it.sa = $urandom;
    it.da = $urandom;
    it.sm = $urandom;
    it.dm = $urandom;
    it.pr = ProtoW'($urandom);
    it.act = ActionW'($urandom);
    it.sp = PortW'($urandom);
    it.sph = PortW'($urandom);
    it.dp = PortW'($urandom);
    it.dph = PortW'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      // rule write with coarse masks and mostly sane port ranges so packets can hit
      it.mode = MODE_WRITE;
      it.sa = $urandom_range(3) << 30 | ($urandom & 32'h3fff_ffff);
      it.da = $urandom_range(3) << 30 | ($urandom & 32'h3fff_ffff);
      it.sm = ($urandom_range(3) == 0) ? $urandom : 32'hffff_ffff << $urandom_range(32, 28);
      it.dm = ($urandom_range(3) == 0) ? $urandom : 32'hffff_ffff << $urandom_range(32, 28);
      a = PortW'($urandom_range(1023));
      b = PortW'($urandom_range(1023));
      if ($urandom_range(9) != 0 && a > b) begin it.sp = b; it.sph = a; end
      else begin it.sp = a; it.sph = b; end
      a = PortW'($urandom_range(1023));
      b = PortW'($urandom_range(1023));
      if ($urandom_range(9) != 0 && a > b) begin it.dp = b; it.dph = a; end
      else begin it.dp = a; it.dph = b; end
      if ($urandom_range(4) == 0) begin it.sp = 0; it.sph = 16'hffff; end
      it.pr = ($urandom_range(1) != 0) ? 8'd0 : ProtoW'($urandom_range(8));
      if ($urandom_range(9) == 0) it.pr = ProtoW'($urandom);
    end else if (pick < 38) begin
      it.mode = MODE_CLEAR;
    end else if (pick < 41) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_CLASSIFY;
      if ($urandom_range(9) != 0) begin
        it.sa = $urandom_range(3) << 30 | ($urandom & 32'h3fff_ffff);
        it.da = $urandom_range(3) << 30 | ($urandom & 32'h3fff_ffff);
        it.sp = PortW'($urandom_range(1100));
        it.dp = PortW'($urandom_range(1100));
        it.pr = ProtoW'($urandom_range(8));
      end
    end
    return it;
  endfunction

  function automatic item_t make_item(bit [1:0] m, bit [IndexW-1:0] i, bit [AddrW-1:0] sa,
                                      bit [AddrW-1:0] sm, bit [AddrW-1:0] da,
                                      bit [AddrW-1:0] dm, bit [PortW-1:0] sp,
                                      bit [PortW-1:0] sph, bit [PortW-1:0] dp,
                                      bit [PortW-1:0] dph, bit [ProtoW-1:0] pr,
                                      bit [ActionW-1:0] act);
    item_t it;
    it = '{m, i, sa, sm, da, dm, sp, sph, dp, dph, pr, act};
    return it;
  endfunction

  initial begin
    #400000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, extremes, match any, precedence, empty range, overwrite, clear
    send_word(make_item(MODE_CLASSIFY, 0, '1, 0, '1, 0, '1, 0, '1, 0, '1, 0));
    send_word(make_item(MODE_WRITE, 63, 0, 0, 0, 0, 0, 16'hffff, 0, 16'hffff, 0, 8'hff));
    send_word(make_item(MODE_CLASSIFY, 5, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_word(make_item(MODE_WRITE, 10, 32'hc0a8_0100, 32'hffff_ff00, 32'h0a00_0001,
                        '1, 80, 80, 443, 443, 6, 8'h5a));
    send_word(make_item(MODE_CLASSIFY, 0, 32'hc0a8_01fe, 0, 32'h0a00_0001, 0, 80, 0, 443,
                        0, 6, 0));
    send_word(make_item(MODE_CLASSIFY, 0, 32'hc0a8_01fe, 0, 32'h0a00_0001, 0, 80, 0, 443,
                        0, 17, 0));
    send_word(make_item(MODE_CLASSIFY, 0, 32'hc0a8_01fe, 0, 32'h0a00_0001, 0, 81, 0, 443,
                        0, 6, 0));
    send_word(make_item(MODE_WRITE, 0, '1, '1, '1, '1, 100, 50, 0, 16'hffff, 0, 1));
    send_word(make_item(MODE_CLASSIFY, 0, '1, 0, '1, 0, 75, 0, 9, 0, 1, 0));
    send_word(make_item(MODE_WRITE, 0, '1, '1, '1, '1, 0, 16'hffff, 0, 16'hffff, 255, 2));
    send_word(make_item(MODE_CLASSIFY, 0, '1, 0, '1, 0, 16'hffff, 0, 0, 0, 255, 0));
    send_word(make_item(MODE_CLASSIFY, 0, '1, 0, '1, 0, 16'hffff, 0, 0, 0, 254, 0));
    send_word(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_item(MODE_CLASSIFY, 0, '1, 0, '1, 0, 16'hffff, 0, 0, 0, 255, 0));
    send_word(make_item(MODE_UNUSED, 63, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_word(make_item(MODE_CLEAR, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_item(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_item(MODE_CLEAR, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // random part in idling phases, with one long receiver hold-off
    for (int n = 0; n < NumRandom; n++) begin
      case (n * 5 / NumRandom)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (n == NumRandom * 4 / 5) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      send_word(rand_item());
    end
    in_valid_i <= 0;

    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (Slots + 10) @(posedge clk_i);
    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/ftfm_pkg.sv
rtl/core/ftfm_cell.sv
rtl/core/five_tuple_first_match_classifier.sv
tb/tb_five_tuple_first_match_classifier.sv
